// ----- rtl/bapl_pkg.sv -----
// Shared types, constants and helper functions of the mosaic block averager.
// No dependencies; every other file of the block but bapl_ram uses this package.
`timescale 1ns / 1ps

package bapl_pkg;

    // Block geometry
    localparam int BLOCK_SIDE = 3;
    localparam int MAX_PIXELS = BLOCK_SIDE * BLOCK_SIDE;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W      = $clog2(255 * MAX_PIXELS + 1);

    // Colour table
    localparam int TBL_DEPTH  = 32768;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int COLOUR_W   = 16;

    // Stream widths
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 16;

    // tuser item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    // Posterize thresholds and levels
    localparam int TH_LOW  = 42;
    localparam int TH_MID  = 128;
    localparam int TH_HIGH = 212;
    localparam logic [7:0] LVL_1 = 8'd85;
    localparam logic [7:0] LVL_2 = 8'd170;
    localparam logic [7:0] LVL_3 = 8'd255;

    // Luminance weights and limits
    localparam logic [7:0] LUM_WR   = 8'd77;
    localparam logic [7:0] LUM_WG   = 8'd150;
    localparam logic [7:0] LUM_WB   = 8'd29;
    localparam logic [7:0] DARK_LIM = 8'd30;
    localparam logic [7:0] DARK_AMT = 8'd30;
    localparam logic [7:0] WHITE_LIM = 8'd220;

    // Controller to datapath commands
    typedef struct packed {
        logic pix_acc;   // add accepted pixel to the block sums
        logic tbl_wr;    // store accepted table word
        logic post;      // posterize the closed block, clear sums
        logic lum;       // luminance adjust and pack
        logic tbl_rd;    // read colour table at packed colour
        logic out_load;  // load the output register
    } bapl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tbl_en;    // colour table mapping enabled
        logic out_full;  // output register holds an item that m_tready does not take this cycle
    } bapl_sts_t;

    // floor(s / n) < k  <=>  s < k * n, so the average never needs a divider
    function automatic logic [7:0] posterize(input logic [SUM_W-1:0] s,
                                             input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] n_ext;
        logic [SUM_W-1:0] lim_lo;
        logic [SUM_W-1:0] lim_mid;
        logic [SUM_W-1:0] lim_hi;
        logic [7:0]       lvl;
        n_ext   = SUM_W'(n);
        lim_lo  = SUM_W'(TH_LOW) * n_ext;
        lim_mid = SUM_W'(TH_MID) * n_ext;
        lim_hi  = SUM_W'(TH_HIGH) * n_ext;
        if (s < lim_lo)
            lvl = 8'd0;
        else if (s < lim_mid)
            lvl = LVL_1;
        else if (s < lim_hi)
            lvl = LVL_2;
        else
            lvl = LVL_3;
        return lvl;
    endfunction

    function automatic logic [7:0] darken(input logic [7:0] v);
        return (v > DARK_AMT) ? (v - DARK_AMT) : 8'd0;
    endfunction

endpackage

// ----- rtl/bapl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the colour table.
`timescale 1ns / 1ps

module bapl_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/bapl_ctrl.sv -----
// Sequencer of the mosaic block averager: handshakes and step commands.
// Depends on bapl_pkg.
`timescale 1ns / 1ps

module bapl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tlast,
    input  logic                s_tuser,
    input  bapl_pkg::bapl_sts_t sts,
    output bapl_pkg::bapl_cmd_t cmd
);

    import bapl_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POST = 3'd1;
    localparam logic [2:0] ST_LUM  = 3'd2;
    localparam logic [2:0] ST_LOOK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.pix_acc  = accept && (s_tuser == KIND_PIXEL);
        cmd.tbl_wr   = accept && (s_tuser == KIND_TABLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == KIND_PIXEL) && s_tlast)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                cmd.post   = 1'b1;
                state_next = ST_LUM;
            end
            ST_LUM:
            begin
                cmd.lum    = 1'b1;
                state_next = sts.tbl_en ? ST_LOOK : ST_DONE;
            end
            ST_LOOK:
            begin
                cmd.tbl_rd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/bapl_datapath.sv -----
// Datapath: block sums, posterize, luminance adjust, colour table, output register.
// Depends on bapl_pkg and bapl_ram.
`timescale 1ns / 1ps

module bapl_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bapl_pkg::bapl_cmd_t        cmd,
    output bapl_pkg::bapl_sts_t        sts,
    input  logic [bapl_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                       cfg_valid,
    input  logic                       cfg_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [bapl_pkg::M_DATA_W-1:0] m_tdata
);

    import bapl_pkg::*;

    logic [15:0]        pixel;
    logic [TBL_AW-1:0]  table_address;
    logic [15:0]        table_word;

    logic [SUM_W-1:0]   red_sum_reg,   red_sum_next;
    logic [SUM_W-1:0]   green_sum_reg, green_sum_next;
    logic [SUM_W-1:0]   blue_sum_reg,  blue_sum_next;
    logic [CNT_W-1:0]   count_reg,     count_next;

    logic [7:0]         r_lvl_reg, g_lvl_reg, b_lvl_reg;
    logic [15:0]        colour_reg;
    logic [15:0]        colour_next;
    logic               table_enable_reg;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg;

    logic [15:0]        lum_sum;
    logic [7:0]         lum;
    logic [7:0]         r_adj, g_adj, b_adj;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic [15:0]        tbl_rdata;

    // Input fields
    assign pixel         = s_tdata[15:0];
    assign table_address = s_tdata[30:16];
    assign table_word    = s_tdata[46:31];

    // Block sums: add 8-bit-expanded channels until the block is full
    always_comb
    begin
        red_sum_next   = red_sum_reg;
        green_sum_next = green_sum_reg;
        blue_sum_next  = blue_sum_reg;
        count_next     = count_reg;
        if (cmd.post)
        begin
            red_sum_next   = '0;
            green_sum_next = '0;
            blue_sum_next  = '0;
            count_next     = '0;
        end
        else if (cmd.pix_acc && (count_reg < CNT_W'(MAX_PIXELS)))
        begin
            red_sum_next   = red_sum_reg   + SUM_W'({pixel[15:11], 3'b000});
            green_sum_next = green_sum_reg + SUM_W'({pixel[10:5], 2'b00});
            blue_sum_next  = blue_sum_reg  + SUM_W'({pixel[4:0], 3'b000});
            count_next     = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
            count_reg     <= '0;
        end
        else
        begin
            red_sum_reg   <= red_sum_next;
            green_sum_reg <= green_sum_next;
            blue_sum_reg  <= blue_sum_next;
            count_reg     <= count_next;
        end
    end

    // Posterize stage
    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            r_lvl_reg <= posterize(red_sum_reg, count_reg);
            g_lvl_reg <= posterize(green_sum_reg, count_reg);
            b_lvl_reg <= posterize(blue_sum_reg, count_reg);
        end
    end

    // Luminance, dark/bright adjust and RGB565 pack
    assign lum_sum = (16'(r_lvl_reg) * 16'(LUM_WR)) + (16'(g_lvl_reg) * 16'(LUM_WG))
                   + (16'(b_lvl_reg) * 16'(LUM_WB));
    assign lum     = lum_sum[15:8];

    always_comb
    begin
        r_adj = r_lvl_reg;
        g_adj = g_lvl_reg;
        b_adj = b_lvl_reg;
        if (lum < DARK_LIM)
        begin
            r_adj = darken(r_lvl_reg);
            g_adj = darken(g_lvl_reg);
            b_adj = darken(b_lvl_reg);
        end
        else if (lum > WHITE_LIM)
        begin
            r_adj = 8'hFF;
            g_adj = 8'hFF;
            b_adj = 8'hFF;
        end
        colour_next = {r_adj[7:3], g_adj[7:2], b_adj[7:3]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lum)
            colour_reg <= colour_next;
    end

    // Colour table: index drops the low green bit
    assign tbl_raddr = {colour_reg[15:6], colour_reg[4:0]};

    bapl_ram #(
        .DATA_W (COLOUR_W),
        .DEPTH  (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.tbl_wr),
        .waddr (table_address),
        .wdata (table_word),
        .re    (cmd.tbl_rd),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_enable_reg <= 1'b0;
        else if (cfg_valid)
            table_enable_reg <= cfg_data;
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= table_enable_reg ? tbl_rdata : colour_reg;
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign sts.tbl_en   = table_enable_reg;
    assign sts.out_full = out_valid_reg && !m_tready;

endmodule

// ----- rtl/block_average_posterize_lut_top.sv -----
// Top level of the mosaic block averager with posterize and colour table.
// Depends on bapl_pkg, bapl_ctrl, bapl_datapath (and through it bapl_ram).
//
//  channel   | direction | signals                          | item
//  ----------+-----------+----------------------------------+-----------------------------
//  s_*       | in        | tvalid tready tdata tlast tuser  | block pixel or table write
//  m_*       | out       | tvalid tready tdata              | RGB565 block colour
//  cfg_*     | in        | valid ready data                 | table_enable register write
//
// A pixel that does not end a block, and a table write, leave the input open for the next item.
// A block-ending pixel closes the input through the posterize, luminance adjust and
// load steps, with a registered colour table read step before the load when the table is on.
// The output register frees the input at once; a stalled m_tready holds the sequencer at
// its load step only while the output register still holds an earlier colour. Reset clears
// the sums, the count, the enable bit and the output valid; the table contents stay undefined.
`timescale 1ns / 1ps

module block_average_posterize_lut_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel[15:0], table_address[30:16], table_word[46:31]
    input  logic        s_tlast,   // block_end
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // block_colour[15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // table_enable
);

    import bapl_pkg::*;

    bapl_cmd_t cmd;
    bapl_sts_t sts;

    assign cfg_ready = 1'b1;

    bapl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    bapl_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- rtl/bapl_checker.sv -----
// Port-level checks of the mosaic block averager, bound to the top level.
// Depends on bapl_pkg for the item kinds and on the top level's ports.
`timescale 1ns / 1ps

module bapl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A waiting block colour holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("block colour dropped or changed while stalled");

    // A block-ending pixel closes the input while the colour is worked out
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == bapl_pkg::KIND_PIXEL) && s_tlast
        |=> !s_tready)
        else $error("input open right after a block end");

    // No accepted item makes a colour appear in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid)))
        else $error("block colour appeared too early");

    // Table writes never end a block: the input stays open after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == bapl_pkg::KIND_TABLE) |=> s_tready)
        else $error("table write stalled the input");

endmodule

bind block_average_posterize_lut_top bapl_checker u_bapl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking testbench of block_average_posterize_lut_top: streams pixel and
// colour table write items, predicts every block colour and checks it in order.
// Depends on bapl_pkg and the RTL of the block; reads no files.

module testbench;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 235;
    localparam int NUM_PHASES    = 5;

    // One input item, unpacked
    typedef struct {
        bit        kind;
        bit [15:0] pixel;
        bit        block_end;
        bit [14:0] table_address;
        bit [15:0] table_word;
    } stream_item_t;

    // Directed stimulus row; typed rows carry a hand-computed colour
    typedef struct {
        stream_item_t item;
        bit           typed;
        bit [15:0]    colour;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // pixel[15:0], table_address[30:16], table_word[46:31]
    logic        s_tlast   = 1'b0; // block_end
    logic        s_tuser   = 1'b0; // kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // block_colour[15:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0; // table_enable

    // Predictor state
    bit [11:0] red_acc;
    bit [11:0] green_acc;
    bit [11:0] blue_acc;
    bit [3:0]  pix_cnt;
    bit        lut_on;
    bit [15:0] lut_shadow [0:32767];

    bit [15:0] colour_queue [$];
    bit [14:0] readable_addrs [$];
    dir_row_t  dir_rows [$];

    bit no_idle = 1'b0;
    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    int colours_checked = 0;
    int table_writes = 0;

    block_average_posterize_lut_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d colours still pending",
                     cycles, colour_queue.size());
            $display("block_average_posterize_lut_top: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input bit [15:0] want,
                                   input bit [15:0] got);
        $display("[%0t] %s: expected %04h, got %04h", $time, what, want, got);
        errors++;
    endtask

    // Four output levels of a channel average
    function automatic int quantize_level(input int avg);
        if (avg < 42)
            return 0;
        else if (avg < 128)
            return 85;
        else if (avg < 212)
            return 170;
        return 255;
    endfunction

    function automatic int dim_channel(input int v);
        return (v > 30) ? v - 30 : 0;
    endfunction

    // Channel values that can reach the table lookup
    function automatic int channel_value(input int i);
        case (i)
            0: return 0;
            1: return 55;
            2: return 85;
            3: return 140;
            4: return 170;
            5: return 225;
            default: return 255;
        endcase
    endfunction

    // Expected block colour of one accepted item
    task automatic predict_item(input stream_item_t it, output bit has_colour,
                                output bit [15:0] colour);
        int r;
        int g;
        int b;
        int lum;
        bit [14:0] idx;
        has_colour = 1'b0;
        colour = '0;
        if (it.kind == bapl_pkg::KIND_TABLE)
        begin
            lut_shadow[it.table_address] = it.table_word;
            table_writes++;
            return;
        end
        // pixels past the block capacity are dropped
        if (pix_cnt < bapl_pkg::MAX_PIXELS)
        begin
            red_acc   += {4'd0, it.pixel[15:11], 3'd0};
            green_acc += {4'd0, it.pixel[10:5], 2'd0};
            blue_acc  += {4'd0, it.pixel[4:0], 3'd0};
            pix_cnt++;
        end
        if (!it.block_end)
            return;
        r = quantize_level(int'(red_acc) / int'(pix_cnt));
        g = quantize_level(int'(green_acc) / int'(pix_cnt));
        b = quantize_level(int'(blue_acc) / int'(pix_cnt));
        lum = (r * 77 + g * 150 + b * 29) >> 8;
        if (lum < 30)
        begin
            r = dim_channel(r);
            g = dim_channel(g);
            b = dim_channel(b);
        end
        else if (lum > 220)
        begin
            r = 255;
            g = 255;
            b = 255;
        end
        colour = {r[7:3], g[7:2], b[7:3]};
        if (lut_on)
        begin
            idx = {colour[15:6], colour[4:0]};
            colour = lut_shadow[idx];
        end
        red_acc   = '0;
        green_acc = '0;
        blue_acc  = '0;
        pix_cnt   = '0;
        has_colour = 1'b1;
    endtask

    // Drive one item at the falling edge, wait for acceptance, then predict
    task automatic send_item(input stream_item_t it, input bit typed,
                             input bit [15:0] typed_colour);
        bit has_colour;
        bit [15:0] colour;
        while (!no_idle && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tlast  <= it.block_end;
        s_tdata  <= {1'b0, it.table_word, it.table_address, it.pixel};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(it, has_colour, colour);
        if (has_colour)
            colour_queue.push_back(typed ? typed_colour : colour);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(input bit kind, input bit [15:0] pixel, input bit block_end,
                           input bit [14:0] addr, input bit [15:0] word,
                           input bit typed, input bit [15:0] colour);
        dir_row_t row;
        row.item.kind          = kind;
        row.item.pixel         = pixel;
        row.item.block_end     = block_end;
        row.item.table_address = addr;
        row.item.table_word    = word;
        row.typed              = typed;
        row.colour             = colour;
        dir_rows.push_back(row);
    endtask

    // Register write; only issued while the block is idle
    task automatic write_table_enable(input bit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        lut_on = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (colour_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic stream_item_t random_table_write();
        stream_item_t it;
        it.kind      = bapl_pkg::KIND_TABLE;
        it.pixel     = 16'($urandom);
        it.block_end = 1'($urandom_range(1));
        if ($urandom_range(1) == 1)
            it.table_address = readable_addrs[$urandom_range(readable_addrs.size() - 1)];
        else
            it.table_address = 15'($urandom);
        it.table_word = 16'($urandom);
        return it;
    endfunction

    // One random block, with table writes mixed in and some over-long blocks
    task automatic gen_block();
        int n;
        int mode;
        bit [15:0] base;
        stream_item_t it;
        n = ($urandom_range(9) == 0) ? $urandom_range(14, 10) : $urandom_range(9, 1);
        mode = $urandom_range(3);
        base = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(random_table_write(), 1'b0, '0);
            it.kind = bapl_pkg::KIND_PIXEL;
            case (mode)
                0: it.pixel = 16'($urandom);
                1: it.pixel = base;
                2: it.pixel = 16'($urandom) | 16'hC618;   // bright
                default: it.pixel = 16'($urandom) & 16'h39E7;  // dark
            endcase
            it.block_end     = (i == n - 1);
            it.table_address = 15'($urandom);
            it.table_word    = 16'($urandom);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls except in the quiet phase
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= no_idle || ($urandom_range(99) >= 8);
    end

    // Output checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (colour_queue.size() == 0)
                report_mismatch("block colour with none pending", '0, m_tdata);
            else
            begin
                if (m_tdata !== colour_queue[0])
                    report_mismatch("block_colour", colour_queue[0], m_tdata);
                void'(colour_queue.pop_front());
                colours_checked++;
            end
        end
    end

    initial
    begin
        stream_item_t it;
        int phase_start;
        bit phase_enable [NUM_PHASES];

        // addresses the lookup can ever read
        for (int ri = 0; ri < 7; ri++)
            for (int gi = 0; gi < 7; gi++)
                for (int bi = 0; bi < 7; bi++)
                    readable_addrs.push_back({5'(channel_value(ri) >> 3),
                                              5'(channel_value(gi) >> 3),
                                              5'(channel_value(bi) >> 3)});

        // directed rows: extremes, ignored fields, table write inside a block,
        // over-long block, dark and white adjustment
        add_row(1'b0, 16'h0000, 1'b1, 15'h0000, 16'h0000, 1'b1, 16'h0000);
        add_row(1'b0, 16'hFFFF, 1'b1, 15'h0000, 16'h0000, 1'b1, 16'hFFFF);
        add_row(1'b0, 16'h0000, 1'b1, 15'h7FFF, 16'hFFFF, 1'b1, 16'h0000);
        add_row(1'b1, 16'hFFFF, 1'b1, 15'h0000, 16'h0000, 1'b0, 16'h0000);
        add_row(1'b1, 16'h0000, 1'b0, 15'h7FFF, 16'hFFFF, 1'b0, 16'h0000);
        add_row(1'b0, 16'hF800, 1'b0, 15'h0000, 16'h0000, 1'b0, 16'h0000);
        add_row(1'b0, 16'hF800, 1'b0, 15'h0000, 16'h0000, 1'b0, 16'h0000);
        add_row(1'b0, 16'hF800, 1'b1, 15'h0000, 16'h0000, 1'b1, 16'hF800);
        add_row(1'b0, 16'h07E0, 1'b0, 15'h0000, 16'h0000, 1'b0, 16'h0000);
        add_row(1'b1, 16'h0000, 1'b0, 15'h1234, 16'h5555, 1'b0, 16'h0000);
        add_row(1'b0, 16'h07E0, 1'b1, 15'h0000, 16'h0000, 1'b1, 16'h07E0);
        for (int k = 0; k < 9; k++)
            add_row(1'b0, 16'hFFFF, 1'b0, 15'h0000, 16'h0000, 1'b0, 16'h0000);
        add_row(1'b0, 16'h0000, 1'b1, 15'h0000, 16'h0000, 1'b1, 16'hFFFF);
        add_row(1'b0, 16'h001F, 1'b1, 15'h0000, 16'h0000, 1'b1, 16'h001C);
        add_row(1'b0, 16'h8410, 1'b1, 15'h0000, 16'h0000, 1'b1, 16'hAD55);
        add_row(1'b0, 16'h2945, 1'b0, 15'h0000, 16'h0000, 1'b0, 16'h0000);
        add_row(1'b0, 16'h3186, 1'b1, 15'h0000, 16'h0000, 1'b0, 16'h0000);

        phase_enable[0] = 1'b1;
        phase_enable[1] = 1'b0;
        phase_enable[2] = 1'b1;
        phase_enable[3] = 1'b1;
        phase_enable[4] = 1'b0;

        // reset, predictor back to its reset state
        red_acc   = '0;
        green_acc = '0;
        blue_acc  = '0;
        pix_cnt   = '0;
        lut_on    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_table_enable(1'b0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].colour);
        wait_idle();

        // fill every entry the lookup can reach before mapping is enabled
        foreach (readable_addrs[i])
        begin
            it.kind          = bapl_pkg::KIND_TABLE;
            it.pixel         = 16'($urandom);
            it.block_end     = 1'($urandom_range(1));
            it.table_address = readable_addrs[i];
            it.table_word    = 16'($urandom);
            send_item(it, 1'b0, '0);
        end
        wait_idle();

        // random phases with table mapping on, off, on, on and off
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_table_enable(phase_enable[p]);
            no_idle = (p == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                gen_block();
            wait_idle();
        end
        no_idle = 1'b0;

        $display("sent %0d items (%0d table writes), checked %0d block colours",
                 items_sent, table_writes, colours_checked);
        $display("covered table mapping off and on, over-long blocks, stalls on both sides");
        if (errors == 0 && colour_queue.size() == 0)
            $display("block_average_posterize_lut_top: match");
        else
            $display("block_average_posterize_lut_top: mismatch");
        $finish;
    end

endmodule
